// ----- hw/rtl/tsg_pkg.sv -----
// Shared types and constants for the touch slot event generator.
// No dependencies; every other file of the block refers to this package.
package tsg_pkg;

	localparam int unsigned COORD_W = 12;
	localparam int unsigned ID_W    = 4;
	localparam int unsigned KIND_W  = 2;

	localparam logic [KIND_W-1:0] KIND_DOWN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MOVE = 2'd2;

	typedef struct packed {
		logic               func;
		logic [ID_W-1:0]    finger_id;
		logic [COORD_W-1:0] raw_x;
		logic [COORD_W-1:0] raw_y;
	} point_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]  event_kind;
		logic [ID_W-1:0]    slot;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic               last_event;
	} evt_item_t;

	// Pending event record held by each cell and shifted along the row.
	typedef struct packed {
		logic      valid;
		evt_item_t item;
	} evt_rec_t;

	// Control broadcast from the frame controller to every cell.
	typedef struct packed {
		logic               point;
		logic [ID_W-1:0]    idx;
		logic [COORD_W-1:0] new_x;
		logic [COORD_W-1:0] new_y;
		logic               eof;
		logic               shift;
	} cell_cmd_t;

endpackage

// ----- hw/rtl/tsg_slot_cell.sv -----
// One finger slot: stored position, presence and move flags, and an event record.
// Depends on tsg_pkg; instantiated in a row by touch_slot_event_generator_core.
module tsg_slot_cell #(
	parameter int unsigned SLOT_IDX = 0,
	parameter int unsigned KEEP_W   = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tsg_pkg::cell_cmd_t cmd,
	input  tsg_pkg::evt_rec_t  rec_in,
	input  logic              any_above_in,
	output logic              any_above_out,
	output tsg_pkg::evt_rec_t  rec_out
);

	logic [KEEP_W-1:0]  pos_x_q;
	logic [KEEP_W-1:0]  pos_y_q;
	logic               prev_q;
	logic               now_q;
	logic               moved_q;
	tsg_pkg::evt_rec_t  rec_q;

	logic                       hit;
	logic [KEEP_W-1:0]          nx;
	logic [KEEP_W-1:0]          ny;
	logic                       ev_valid;
	logic [tsg_pkg::KIND_W-1:0] ev_kind;

	assign hit = cmd.point && (cmd.idx == tsg_pkg::ID_W'(SLOT_IDX));
	assign nx  = cmd.new_x[KEEP_W-1:0];
	assign ny  = cmd.new_y[KEEP_W-1:0];

	always_comb begin
		ev_valid = 1'b0;
		ev_kind  = tsg_pkg::KIND_MOVE;
		if (now_q != prev_q) begin
			ev_valid = 1'b1;
			ev_kind  = now_q ? tsg_pkg::KIND_DOWN : tsg_pkg::KIND_UP;
		end else if (now_q && moved_q) begin
			ev_valid = 1'b1;
		end
	end

	assign any_above_out = any_above_in | ev_valid;
	assign rec_out       = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			prev_q  <= 1'b0;
			now_q   <= 1'b0;
			moved_q <= 1'b0;
			rec_q   <= '0;
		end else begin
			if (hit) begin
				if ((nx != pos_x_q) || (ny != pos_y_q)) begin
					pos_x_q <= nx;
					pos_y_q <= ny;
					moved_q <= 1'b1;
				end
				now_q <= 1'b1;
			end
			if (cmd.eof) begin
				rec_q.valid           <= ev_valid;
				rec_q.item.event_kind <= ev_kind;
				rec_q.item.slot       <= tsg_pkg::ID_W'(SLOT_IDX);
				rec_q.item.pos_x      <= tsg_pkg::COORD_W'(pos_x_q);
				rec_q.item.pos_y      <= tsg_pkg::COORD_W'(pos_y_q);
				rec_q.item.last_event <= ev_valid & ~any_above_in;
				prev_q                <= now_q;
				now_q                 <= 1'b0;
				moved_q               <= 1'b0;
			end else if (cmd.shift) begin
				rec_q <= rec_in;
			end
		end
	end

endmodule

// ----- hw/rtl/touch_slot_event_generator_core.sv -----
// Top level of the touch slot event generator: frame controller, slot row, output register.
// Depends on tsg_pkg and tsg_slot_cell.

// A frame is a run of point transfers closed by one end-of-frame transfer. A point
// transfer updates its slot when it is taken. At the end of a frame every slot cell
// latches its pending event, and the records then shift one cell per cycle towards
// slot 0, which feeds the output register, except while the output side stalls with
// an event at the head; slots without an event are shifted through as well. The block
// therefore accepts nothing after an end-of-frame transfer until all SLOT_COUNT records
// have shifted out, and events leave in ascending slot order with the final one flagged.
module touch_slot_event_generator_core #(
	parameter int unsigned SLOT_COUNT        = 10,
	parameter int unsigned FRAME_POINT_LIMIT = 10,
	parameter int unsigned COORD_BITS        = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	output logic                 frame_ready,
	input  tsg_pkg::point_item_t frame_item,
	output logic                 evt_valid,
	input  logic                 evt_ready,
	output tsg_pkg::evt_item_t   evt_item
);

	localparam int unsigned KEEP_W =
		(COORD_BITS < tsg_pkg::COORD_W) ? COORD_BITS : tsg_pkg::COORD_W;
	localparam int unsigned PCNT_W = $clog2(FRAME_POINT_LIMIT + 1);
	localparam int unsigned SCAN_W = $clog2(SLOT_COUNT + 1);

	logic [PCNT_W-1:0]   pcnt_q;
	logic [SCAN_W-1:0]   scan_q;
	logic                out_valid_q;
	tsg_pkg::evt_item_t  out_item_q;

	tsg_pkg::cell_cmd_t  cmd;
	tsg_pkg::evt_rec_t   rec_chain [SLOT_COUNT+1];
	logic                any_chain [SLOT_COUNT+1];

	logic accept;
	logic room;
	logic id_ok;
	logic out_free;
	logic head_take;

	assign frame_ready = (scan_q == '0);
	assign accept      = frame_valid && frame_ready;
	assign room        = (pcnt_q < PCNT_W'(FRAME_POINT_LIMIT));
	assign id_ok       = (frame_item.finger_id != '0) &&
	                     (frame_item.finger_id <= tsg_pkg::ID_W'(SLOT_COUNT));
	assign out_free    = !out_valid_q || evt_ready;

	always_comb begin
		cmd.point = accept && !frame_item.func && room && id_ok;
		cmd.idx   = frame_item.finger_id - tsg_pkg::ID_W'(1);
		cmd.new_x = frame_item.raw_y;
		cmd.new_y = frame_item.raw_x;
		cmd.eof   = accept && frame_item.func;
		cmd.shift = (scan_q != '0) && (!rec_chain[0].valid || out_free);
	end

	assign head_take = cmd.shift && rec_chain[0].valid;

	assign rec_chain[SLOT_COUNT] = '0;
	assign any_chain[SLOT_COUNT] = 1'b0;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		tsg_slot_cell #(
			.SLOT_IDX (i),
			.KEEP_W   (KEEP_W)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cmd           (cmd),
			.rec_in        (rec_chain[i+1]),
			.any_above_in  (any_chain[i+1]),
			.any_above_out (any_chain[i]),
			.rec_out       (rec_chain[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q      <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.eof) begin
				pcnt_q <= '0;
				scan_q <= SCAN_W'(SLOT_COUNT);
			end else begin
				if (accept && room) begin
					pcnt_q <= pcnt_q + PCNT_W'(1);
				end
				if (cmd.shift) begin
					scan_q <= scan_q - SCAN_W'(1);
				end
			end
			if (head_take) begin
				out_valid_q <= 1'b1;
			end else if (evt_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_take) begin
			out_item_q <= rec_chain[0].item;
		end
	end

	assign evt_valid = out_valid_q;
	assign evt_item  = out_item_q;

endmodule
